[sv/tqs_pkg.sv]
// tqs_pkg: shared constants, codes and word types for the timer queue scheduler
// no dependencies; used by tqs_slot_store, tqs_scan and timer_queue_scheduler
package tqs_pkg;

   localparam int TIMER_SLOTS = 16;
   localparam int SLOT_W      = $clog2(TIMER_SLOTS);
   localparam int MAX_RESULTS = 16;
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

   localparam logic [1:0] REQ_ADD    = 2'd0;
   localparam logic [1:0] REQ_CANCEL = 2'd1;
   localparam logic [1:0] REQ_TICK   = 2'd2;

   localparam logic [2:0] ST_ADDED   = 3'd0;
   localparam logic [2:0] ST_FULL    = 3'd1;
   localparam logic [2:0] ST_CANCEL  = 3'd2;
   localparam logic [2:0] ST_EXPIRED = 3'd3;
   localparam logic [2:0] ST_NO_EXP  = 3'd4;

   localparam logic [31:0] KEY_FLIP = 32'h8000_0000;

   typedef logic [SLOT_W-1:0] slot_addr_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [23:0] delay_ms;
      logic [23:0] period_ms;
      logic [15:0] cancel_id;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] timer_id;
      logic [23:0] next_due_ms;
      logic        last_of_run;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0] id;
      logic [31:0] deadline;
      logic [23:0] period;
   } slot_entry_type;

   typedef struct packed {
      logic           wr_en;
      logic           set_vld;
      logic           clr_vld;
      slot_addr_type  addr;
      slot_entry_type entry;
   } slot_wr_type;

   typedef struct packed {
      logic          clear;
      logic          sample;
      logic          cancel_mode;
      logic          slot_vld;
      slot_addr_type idx;
   } scan_ctl_type;

   typedef struct packed {
      logic          found;
      slot_addr_type idx;
      logic [15:0]   id;
      logic [23:0]   period;
      logic [31:0]   key;
   } scan_res_type;

endpackage

[sv/tqs_slot_store.sv]
// tqs_slot_store: slot memory (id, deadline, period) with registered read,
// per-slot valid flags and lowest-free-slot finder; depends on tqs_pkg
module tqs_slot_store (
   input  logic                          clock,
   input  logic                          reset,
   input  tqs_pkg::slot_wr_type          wr,
   input  tqs_pkg::slot_addr_type        rd_addr,
   output tqs_pkg::slot_entry_type       rd_entry,
   output logic [tqs_pkg::TIMER_SLOTS-1:0] slot_vld,
   output logic                          free_any,
   output tqs_pkg::slot_addr_type        free_idx
);

   tqs_pkg::slot_entry_type mem [tqs_pkg::TIMER_SLOTS];
   tqs_pkg::slot_entry_type rd_entry_ff;
   logic [tqs_pkg::TIMER_SLOTS-1:0] vld_ff, vld_in;

   always_ff @(posedge clock) begin
      if (wr.wr_en) begin
         mem[wr.addr] <= wr.entry;
      end
      rd_entry_ff <= mem[rd_addr];
   end

   always_comb begin
      vld_in = vld_ff;
      if (wr.set_vld) begin
         vld_in[wr.addr] = 1'b1;
      end
      if (wr.clr_vld) begin
         vld_in[wr.addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // lowest free slot
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int s = tqs_pkg::TIMER_SLOTS - 1; s >= 0; s--) begin
         if (!vld_ff[s]) begin
            free_any = 1'b1;
            free_idx = tqs_pkg::SLOT_W'(s);
         end
      end
   end

   assign rd_entry = rd_entry_ff;
   assign slot_vld = vld_ff;

endmodule

[sv/tqs_scan.sv]
// tqs_scan: compare unit fed one slot per cycle during a table pass; keeps the
// earliest deadline (ticks) or the first id match (cancels); depends on tqs_pkg
module tqs_scan (
   input  logic                    clock,
   input  logic                    reset,
   input  tqs_pkg::scan_ctl_type   ctl,
   input  tqs_pkg::slot_entry_type entry,
   input  logic [31:0]             now_ms,
   input  logic [15:0]             cancel_id,
   output tqs_pkg::scan_res_type   res
);

   logic                   found_ff, found_in;
   tqs_pkg::slot_addr_type idx_ff, idx_in;
   logic [15:0]            id_ff, id_in;
   logic [23:0]            period_ff, period_in;
   logic [31:0]            key_ff, key_in;
   logic [31:0]            key;

   assign key = (entry.deadline - now_ms) ^ tqs_pkg::KEY_FLIP;

   always_comb begin
      found_in  = found_ff;
      idx_in    = idx_ff;
      id_in     = id_ff;
      period_in = period_ff;
      key_in    = key_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (ctl.sample && ctl.slot_vld) begin
         if (ctl.cancel_mode) begin
            if (!found_ff && cancel_id != 16'd0 && entry.id == cancel_id) begin
               found_in = 1'b1;
               idx_in   = ctl.idx;
            end
         end else if (!found_ff || key < key_ff) begin
            // strict compare keeps the lower slot on ties
            found_in  = 1'b1;
            idx_in    = ctl.idx;
            id_in     = entry.id;
            period_in = entry.period;
            key_in    = key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      id_ff     <= id_in;
      period_ff <= period_in;
      key_ff    <= key_in;
   end

   assign res = '{found: found_ff, idx: idx_ff, id: id_ff, period: period_ff, key: key_ff};

endmodule

[sv/timer_queue_scheduler.sv]
// timer_queue_scheduler: top level with the request sequencer and result register
// depends on tqs_pkg, tqs_slot_store and tqs_scan
//
// Usage: requests arrive on req_valid/req_ready with a req_word_type word
// (add, cancel or one-millisecond tick). Results leave on rsp_valid/rsp_ready
// as rsp_word_type words; last_of_run marks the final word of a request.
// Request type 3 is taken and dropped without a result.
// Work per request:
//   add:    no table pass; straight to the result register
//   cancel: one full pass over the slot memory
//   tick:   one pass with no expiry, else (k + 1) passes for k expirations
//           (k <= 16), each pass reads one slot per cycle
//           through the single read port
// One request is in work at a time; req_ready is high only when the sequencer
// is idle, while the previous result may still sit in the result register.
// When the receiver stalls, the sequencer holds the next word and waits; no
// word is lost. Reset clears the clock, id counter, valid flags and the
// result valid flag; no clearing pass is needed.
module timer_queue_scheduler (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tqs_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tqs_pkg::rsp_word_type rsp_data
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_DRAIN  = 5'b00100,
      S_DECIDE = 5'b01000,
      S_OUT    = 5'b10000
   } state_type;

   state_type                 state_ff, state_in, ret_ff, ret_in;
   logic [31:0]               now_ff, now_in;
   logic [15:0]               idc_ff, idc_in;
   logic                      cancel_ff, cancel_in;
   logic [15:0]               cid_ff, cid_in;
   tqs_pkg::slot_addr_type    rd_addr_ff, rd_addr_in;
   logic                      smp_ff, smp_in;
   tqs_pkg::slot_addr_type    smp_idx_ff, smp_idx_in;
   logic [tqs_pkg::RES_CNT_W-1:0] cnt_ff, cnt_in;
   logic                      prev_ff, prev_in;
   logic [15:0]               prev_id_ff, prev_id_in;
   tqs_pkg::rsp_word_type     pend_ff, pend_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   tqs_pkg::rsp_word_type     rsp_ff, rsp_in;

   tqs_pkg::slot_wr_type      wr;
   tqs_pkg::slot_entry_type   rd_entry;
   logic [tqs_pkg::TIMER_SLOTS-1:0] slot_vld;
   logic                      free_any;
   tqs_pkg::slot_addr_type    free_idx;
   tqs_pkg::scan_ctl_type     scan_ctl;
   tqs_pkg::scan_res_type     res;
   logic                      scan_clear;

   logic [15:0] id_new;
   logic [31:0] due_gap;
   logic        best_exp;
   logic [23:0] next_due;

   tqs_slot_store u_store (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .rd_addr  (rd_addr_ff),
      .rd_entry (rd_entry),
      .slot_vld (slot_vld),
      .free_any (free_any),
      .free_idx (free_idx)
   );

   assign scan_ctl = '{clear: scan_clear, sample: smp_ff, cancel_mode: cancel_ff,
                       slot_vld: slot_vld[smp_idx_ff], idx: smp_idx_ff};

   tqs_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scan_ctl),
      .entry     (rd_entry),
      .now_ms    (now_ff),
      .cancel_id (cid_ff),
      .res       (res)
   );

   assign id_new   = (idc_ff == 16'hFFFF) ? 16'd1 : idc_ff + 16'd1;
   assign due_gap  = res.key ^ tqs_pkg::KEY_FLIP;
   assign best_exp = res.found && (due_gap == 32'd0 || due_gap[31]);

   always_comb begin
      if (!res.found || due_gap == 32'd0 || due_gap[31]) begin
         next_due = 24'd0;
      end else if (|due_gap[31:24]) begin
         next_due = 24'hFF_FFFF;
      end else begin
         next_due = due_gap[23:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      now_in       = now_ff;
      idc_in       = idc_ff;
      cancel_in    = cancel_ff;
      cid_in       = cid_ff;
      rd_addr_in   = rd_addr_ff;
      cnt_in       = cnt_ff;
      prev_in      = prev_ff;
      prev_id_in   = prev_id_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_in       = rsp_ff;
      wr           = '0;
      scan_clear   = 1'b0;
      smp_in       = (state_ff == S_SCAN);
      smp_idx_in   = rd_addr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_data.req_type)
                  tqs_pkg::REQ_ADD: begin
                     if (free_any) begin
                        idc_in         = id_new;
                        wr.wr_en       = 1'b1;
                        wr.set_vld     = 1'b1;
                        wr.addr        = free_idx;
                        wr.entry.id    = id_new;
                        wr.entry.deadline = now_ff + 32'(req_data.delay_ms);
                        wr.entry.period   = req_data.period_ms;
                        pend_in = '{status: tqs_pkg::ST_ADDED, timer_id: id_new,
                                    next_due_ms: 24'd0, last_of_run: 1'b1};
                     end else begin
                        pend_in = '{status: tqs_pkg::ST_FULL, timer_id: 16'd0,
                                    next_due_ms: 24'd0, last_of_run: 1'b1};
                     end
                     ret_in   = S_IDLE;
                     state_in = S_OUT;
                  end
                  tqs_pkg::REQ_CANCEL: begin
                     cancel_in  = 1'b1;
                     cid_in     = req_data.cancel_id;
                     rd_addr_in = '0;
                     scan_clear = 1'b1;
                     state_in   = S_SCAN;
                  end
                  tqs_pkg::REQ_TICK: begin
                     cancel_in  = 1'b0;
                     now_in     = now_ff + 32'd1;
                     cnt_in     = '0;
                     prev_in    = 1'b0;
                     rd_addr_in = '0;
                     scan_clear = 1'b1;
                     state_in   = S_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            rd_addr_in = rd_addr_ff + 1'b1;
            if (rd_addr_ff == tqs_pkg::SLOT_W'(tqs_pkg::TIMER_SLOTS - 1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (cancel_ff) begin
               wr.clr_vld = res.found;
               wr.addr    = res.idx;
               pend_in = '{status: tqs_pkg::ST_CANCEL,
                           timer_id: res.found ? cid_ff : 16'd0,
                           next_due_ms: 24'd0, last_of_run: 1'b1};
               ret_in   = S_IDLE;
               state_in = S_OUT;
            end else if (best_exp && cnt_ff != tqs_pkg::RES_CNT_W'(tqs_pkg::MAX_RESULTS)) begin
               // rearm periodic entry or free one-shot entry
               wr.addr           = res.idx;
               wr.wr_en          = (res.period != 24'd0);
               wr.clr_vld        = (res.period == 24'd0);
               wr.entry.id       = res.id;
               wr.entry.deadline = now_ff + 32'(res.period);
               wr.entry.period   = res.period;
               cnt_in     = cnt_ff + 1'b1;
               prev_in    = 1'b1;
               prev_id_in = res.id;
               pend_in = '{status: tqs_pkg::ST_EXPIRED, timer_id: prev_id_ff,
                           next_due_ms: 24'd0, last_of_run: 1'b0};
               rd_addr_in = '0;
               scan_clear = 1'b1;
               if (prev_ff) begin
                  ret_in   = S_SCAN;
                  state_in = S_OUT;
               end else begin
                  state_in = S_SCAN;
               end
            end else begin
               if (prev_ff) begin
                  pend_in = '{status: tqs_pkg::ST_EXPIRED, timer_id: prev_id_ff,
                              next_due_ms: next_due, last_of_run: 1'b1};
               end else begin
                  pend_in = '{status: tqs_pkg::ST_NO_EXP, timer_id: 16'd0,
                              next_due_ms: next_due, last_of_run: 1'b1};
               end
               ret_in   = S_IDLE;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pend_ff;
               state_in     = ret_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         now_ff       <= '0;
         idc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         smp_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         now_ff       <= now_in;
         idc_ff       <= idc_in;
         rsp_valid_ff <= rsp_valid_in;
         smp_ff       <= smp_in;
      end
   end

   always_ff @(posedge clock) begin
      cancel_ff  <= cancel_in;
      cid_ff     <= cid_in;
      rd_addr_ff <= rd_addr_in;
      smp_idx_ff <= smp_idx_in;
      cnt_ff     <= cnt_in;
      prev_ff    <= prev_in;
      prev_id_ff <= prev_id_in;
      pend_ff    <= pend_in;
      rsp_ff     <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[bench/testbench.sv]
// testbench: self-checking bench for timer_queue_scheduler with its own timer table model
// depends on tqs_pkg and timer_queue_scheduler; driver and monitor run as clocked processes
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int ID_SPAN = 65535;

   typedef struct packed {
      logic                  aim;
      logic                  quiet;
      tqs_pkg::req_word_type word;
   } pending_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   tqs_pkg::req_word_type req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   tqs_pkg::rsp_word_type rsp_data;

   pending_type           req_backlog[$];
   tqs_pkg::rsp_word_type timer_report_q[$];
   logic         fast_phase = 1'b0;
   int           wait_left = 0;
   int           stall_left = 0;
   int           fault_count = 0;
   int           requests_taken = 0;
   int           expirations = 0;
   int           refusals = 0;
   int           id_wraps = 0;

   // model of the timer table
   logic [31:0]  clock_ms = '0;
   logic [15:0]  last_id = '0;
   logic         live [tqs_pkg::TIMER_SLOTS];
   logic [15:0]  tag [tqs_pkg::TIMER_SLOTS];
   logic [31:0]  due [tqs_pkg::TIMER_SLOTS];
   logic [23:0]  every [tqs_pkg::TIMER_SLOTS];

   timer_queue_scheduler dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   function automatic logic [31:0] rank(input int s);
      return (due[s] - clock_ms) ^ tqs_pkg::KEY_FLIP;
   endfunction

   function automatic logic lapsed(input int s);
      logic [31:0] gap;
      gap = due[s] - clock_ms;
      return gap == 32'd0 || gap[31];
   endfunction

   function automatic logic [23:0] time_to_next();
      logic [31:0] best;
      logic        any;
      int          s;
      any = 1'b0;
      best = '0;
      for (s = 0; s < tqs_pkg::TIMER_SLOTS; s++) begin
         if (live[s] && (!any || rank(s) < best)) begin
            best = rank(s);
            any = 1'b1;
         end
      end
      if (!any) return 24'd0;
      best = best ^ tqs_pkg::KEY_FLIP;
      if (best == 32'd0 || best[31]) return 24'd0;
      return (best > 32'h00FF_FFFF) ? 24'hFF_FFFF : best[23:0];
   endfunction

   function automatic logic [15:0] pick_live_id();
      int s, n, k;
      n = 0;
      for (s = 0; s < tqs_pkg::TIMER_SLOTS; s++) if (live[s]) n++;
      if (n == 0) return 16'($urandom_range(1, ID_SPAN));
      k = $urandom_range(0, n - 1);
      for (s = 0; s < tqs_pkg::TIMER_SLOTS; s++) begin
         if (live[s]) begin
            if (k == 0) return tag[s];
            k--;
         end
      end
      return 16'd0;
   endfunction

   task automatic schedule_request(input tqs_pkg::req_word_type w);
      int                    s, pick, fired;
      logic [15:0]           hit;
      tqs_pkg::rsp_word_type r;
      r = '0;
      r.last_of_run = 1'b1;
      case (w.req_type)
         tqs_pkg::REQ_ADD: begin
            requests_taken++;
            pick = -1;
            for (s = tqs_pkg::TIMER_SLOTS - 1; s >= 0; s--) if (!live[s]) pick = s;
            if (pick < 0) begin
               r.status = tqs_pkg::ST_FULL;
               refusals++;
            end else begin
               last_id = last_id + 16'd1;
               if (last_id == 16'd0) begin
                  last_id = 16'd1;
                  id_wraps++;
               end
               live[pick] = 1'b1;
               tag[pick] = last_id;
               due[pick] = clock_ms + 32'(w.delay_ms);
               every[pick] = w.period_ms;
               r.status = tqs_pkg::ST_ADDED;
               r.timer_id = last_id;
            end
            timer_report_q.push_back(r);
         end
         tqs_pkg::REQ_CANCEL: begin
            requests_taken++;
            hit = 16'd0;
            if (w.cancel_id != 16'd0) begin
               for (s = 0; s < tqs_pkg::TIMER_SLOTS && hit == 16'd0; s++) begin
                  if (live[s] && tag[s] == w.cancel_id) begin
                     live[s] = 1'b0;
                     hit = w.cancel_id;
                  end
               end
            end
            r.status = tqs_pkg::ST_CANCEL;
            r.timer_id = hit;
            timer_report_q.push_back(r);
         end
         tqs_pkg::REQ_TICK: begin
            requests_taken++;
            clock_ms = clock_ms + 32'd1;
            fired = 0;
            pick = 0;
            while (fired < tqs_pkg::MAX_RESULTS && pick >= 0) begin
               pick = -1;
               for (s = 0; s < tqs_pkg::TIMER_SLOTS; s++) begin
                  if (live[s] && lapsed(s) && (pick < 0 || rank(s) < rank(pick))) pick = s;
               end
               if (pick >= 0) begin
                  r = '0;
                  r.status = tqs_pkg::ST_EXPIRED;
                  r.timer_id = tag[pick];
                  timer_report_q.push_back(r);
                  fired++;
                  expirations++;
                  if (every[pick] != 24'd0) due[pick] = clock_ms + 32'(every[pick]);
                  else live[pick] = 1'b0;
               end
            end
            if (fired == 0) begin
               r = '0;
               r.status = tqs_pkg::ST_NO_EXP;
               timer_report_q.push_back(r);
            end
            // distance to the next deadline rides on the closing word
            r = timer_report_q.pop_back();
            r.next_due_ms = time_to_next();
            r.last_of_run = 1'b1;
            timer_report_q.push_back(r);
         end
         default: ;
      endcase
   endtask

   task automatic check_report(input tqs_pkg::rsp_word_type got);
      tqs_pkg::rsp_word_type want;
      if (timer_report_q.size() == 0) begin
         $error("word with no request behind it: status %0d, timer_id %0d",
                got.status, got.timer_id);
         fault_count++;
      end else begin
         want = timer_report_q.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            fault_count++;
         end
         if (got.timer_id !== want.timer_id) begin
            $error("timer_id: expected %0d, actual %0d", want.timer_id, got.timer_id);
            fault_count++;
         end
         if (got.next_due_ms !== want.next_due_ms) begin
            $error("next_due_ms: expected %0d, actual %0d", want.next_due_ms, got.next_due_ms);
            fault_count++;
         end
         if (got.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d, actual %0d", want.last_of_run, got.last_of_run);
            fault_count++;
         end
      end
   endtask

   function automatic tqs_pkg::req_word_type rand_word(input logic [1:0] kind);
      tqs_pkg::req_word_type w;
      w.req_type = kind;
      w.delay_ms = 24'($urandom);
      w.period_ms = 24'($urandom);
      w.cancel_id = 16'($urandom);
      return w;
   endfunction

   function automatic tqs_pkg::req_word_type add_word(input logic [23:0] dly,
                                                      input logic [23:0] per);
      tqs_pkg::req_word_type w;
      w = rand_word(tqs_pkg::REQ_ADD);
      w.delay_ms = dly;
      w.period_ms = per;
      return w;
   endfunction

   function automatic tqs_pkg::req_word_type cancel_word(input logic [15:0] id);
      tqs_pkg::req_word_type w;
      w = rand_word(tqs_pkg::REQ_CANCEL);
      w.cancel_id = id;
      return w;
   endfunction

   function automatic void push_req(input tqs_pkg::req_word_type w, input logic aim,
                                    input logic quiet);
      pending_type p;
      p.word = w;
      p.aim = aim;
      p.quiet = quiet;
      req_backlog.push_back(p);
   endfunction

   // request driver, model updated on every accepted word
   always @(posedge clock) begin : feed_proc
      pending_type nxt;
      logic        offer;
      if (reset) begin
         req_valid <= 1'b0;
         wait_left = 0;
      end else begin
         offer = req_valid;
         if (req_valid && req_ready) begin
            schedule_request(req_data);
            offer = 1'b0;
            if (req_backlog.size() != 0 && req_backlog[0].quiet) wait_left = 0;
            else wait_left = $urandom_range(0, 9);
         end
         if (!offer) begin
            if (wait_left > 0) begin
               wait_left--;
            end else if (req_backlog.size() != 0) begin
               nxt = req_backlog.pop_front();
               if (nxt.aim) nxt.word.cancel_id = pick_live_id();
               req_data <= nxt.word;
               fast_phase <= nxt.quiet;
               offer = 1'b1;
            end
         end
         req_valid <= offer;
      end
   end

   // result monitor with random back-pressure
   always @(posedge clock) begin : take_proc
      logic take;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         take = rsp_ready;
         if (rsp_valid && rsp_ready) begin
            check_report(rsp_data);
            stall_left = fast_phase ? 0 : $urandom_range(0, 9);
            take = 1'b0;
         end
         if (!take) begin
            if (stall_left == 0) take = 1'b1;
            else if (rsp_valid) stall_left--;
         end
         rsp_ready <= take;
      end
   end

   initial begin : stimulus
      tqs_pkg::req_word_type w;
      int                    made, roll, k;
      logic                  calm;
      for (k = 0; k < tqs_pkg::TIMER_SLOTS; k++) begin
         live[k] = 1'b0;
         tag[k] = '0;
         due[k] = '0;
         every[k] = '0;
      end

      // directed: empty tick, cancel misses, unused type, ties and overdue entries
      push_req(rand_word(tqs_pkg::REQ_TICK), 1'b0, 1'b0);
      push_req(cancel_word(16'd0), 1'b0, 1'b0);
      w = '1;
      push_req(w, 1'b0, 1'b0);
      push_req(add_word(24'd0, 24'd0), 1'b0, 1'b0);
      push_req(add_word(24'hFF_FFFF, 24'hFF_FFFF), 1'b0, 1'b0);
      push_req(add_word(24'd1, 24'd1), 1'b0, 1'b0);
      push_req(add_word(24'd2, 24'd0), 1'b0, 1'b0);
      push_req(cancel_word(16'hFFFF), 1'b0, 1'b0);
      push_req(cancel_word(16'd2), 1'b0, 1'b0);
      push_req(add_word(24'd2, 24'hFF_FFFF), 1'b0, 1'b0);
      repeat (3) push_req(rand_word(tqs_pkg::REQ_TICK), 1'b0, 1'b0);
      push_req(cancel_word(16'd3), 1'b0, 1'b0);
      push_req(cancel_word(16'd3), 1'b0, 1'b0);
      push_req(cancel_word(16'd5), 1'b0, 1'b0);

      // random traffic
      calm = 1'b0;
      made = 0;
      while (made < 450) begin
         if ($urandom_range(0, 29) == 0) calm = !calm;
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            push_req(rand_word(REQ_UNUSED), 1'b0, calm);
         end else if (roll < 7) begin
            k = $urandom_range(1, tqs_pkg::TIMER_SLOTS + 1);
            repeat (k) push_req(add_word(24'd0, $urandom_range(0, 1) ? 24'd0 :
                                        24'($urandom_range(1, 5))), 1'b0, calm);
            push_req(rand_word(tqs_pkg::REQ_TICK), 1'b0, calm);
            made += k + 1;
         end else if (roll < 40) begin
            w = rand_word(tqs_pkg::REQ_ADD);
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5, 6: w.delay_ms = 24'($urandom_range(0, 30));
               7: w.delay_ms = 24'd0;
               8: w.delay_ms = 24'($urandom);
               default: w.delay_ms = 24'hFF_FFFF;
            endcase
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: w.period_ms = 24'd0;
               12, 13, 14, 15, 16: w.period_ms = 24'($urandom_range(1, 20));
               17, 18: w.period_ms = 24'($urandom);
               default: w.period_ms = 24'hFF_FFFF;
            endcase
            push_req(w, 1'b0, calm);
            made++;
         end else if (roll < 62) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5, 6, 7: push_req(cancel_word(16'd0), 1'b1, calm);
               8: push_req(cancel_word(16'd0), 1'b0, calm);
               default: push_req(cancel_word(16'($urandom)), 1'b0, calm);
            endcase
            made++;
         end else begin
            push_req(rand_word(tqs_pkg::REQ_TICK), 1'b0, calm);
            made++;
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || req_valid || timer_report_q.size() != 0)
         @(negedge clock);
      repeat (400) @(negedge clock);
      if (timer_report_q.size() != 0) begin
         $error("%0d expected words never arrived", timer_report_q.size());
         fault_count++;
      end
      $display("%0d requests checked: %0d timer expiries, %0d full-table refusals, %0d id wraps",
               requests_taken, expirations, refusals, id_wraps);
      if (fault_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
